// File: rtl/core/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and the byte-wide CRC-16/MODBUS update for the serial
// frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0]  SOF1_BYTE = 8'hAA;
    localparam logic [7:0]  SOF2_BYTE = 8'h55;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_GOOD   = 2'd1,
        EV_CRC    = 2'd2,
        EV_FORMAT = 2'd3
    } t_event;

    typedef enum logic [8:0] {
        PH_SOF1    = 9'b000000001,
        PH_SOF2    = 9'b000000010,
        PH_CMD     = 9'b000000100,
        PH_SEQ     = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CRC_LO  = 9'b010000000,
        PH_CRC_HI  = 9'b100000000
    } t_phase;

    // Reflected CRC, one byte: eight shift/xor steps that flatten to xor logic.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/sof_frame_parser_crc16_core.sv
// ----------------------------------------------------------------------------
// sof_frame_parser_crc16_core
// Byte-stream frame parser: AA 55 CMD SEQ LEN_L LEN_H PAYLOAD CRC_L CRC_H,
// CRC-16/MODBUS checked over CMD through the last payload byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_rx_byte) takes one received byte
//   per word. Output channel (o_valid / i_ready) returns exactly one result
//   word per byte: event code, cmd, seq, length and the three wrapping
//   32-bit counters as they stand after that byte.
//   o_valid rises once the byte has passed two registers: it lands in an
//   input register at the accepting edge, then one pass of parser and CRC
//   logic writes the result register when that register is free or being
//   read. Throughput is one byte per cycle while i_ready stays high, set by
//   the single byte-wide CRC update between those two registers.
//   While the receiver holds i_ready low, the result register holds its
//   word and the input register can still take one more byte; o_ready
//   drops only when both are full.
//   Reset (synchronous, active low) empties both registers, returns the
//   parser to the hunt for the first start byte, sets the running CRC to
//   0xFFFF and clears the counters.
// ----------------------------------------------------------------------------
module sof_frame_parser_crc16_core #(
    parameter int unsigned MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_frame_cmd,
    output logic [7:0]  o_frame_seq,
    output logic [6:0]  o_frame_length,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_crc_errors,
    output logic [31:0] o_format_errors
);
    import sfp_pkg::*;

    localparam int unsigned SeenW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned LenW  = (SeenW > 8) ? SeenW : 8;
    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        w_adv;

    // parser state
    t_phase            r_phase, n_phase;
    logic [7:0]        r_cmd, n_cmd;
    logic [7:0]        r_seq, n_seq;
    logic [LenW-1:0]   r_len, n_len;
    logic [SeenW-1:0]  r_seen, n_seen;
    logic [7:0]        r_crc_lo, n_crc_lo;
    logic [15:0]       r_crc, n_crc;
    logic [31:0]       r_good, n_good;
    logic [31:0]       r_crc_err, n_crc_err;
    logic [31:0]       r_fmt_err, n_fmt_err;

    // result register
    logic        r_out_valid;
    t_event      r_ev, n_ev;
    logic [7:0]  r_o_cmd, n_o_cmd;
    logic [7:0]  r_o_seq, n_o_seq;
    logic [6:0]  r_o_len, n_o_len;

    logic [15:0]      w_crc_b;
    logic [15:0]      w_full_len;
    logic [SeenW-1:0] w_seen_inc;
    logic             w_clear;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    assign w_crc_b    = crc16_byte(r_crc, r_in_byte);
    assign w_full_len = {r_in_byte, r_len[7:0]};
    assign w_seen_inc = r_seen + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_seq     = r_seq;
        n_len     = r_len;
        n_seen    = r_seen;
        n_crc_lo  = r_crc_lo;
        n_crc     = r_crc;
        n_good    = r_good;
        n_crc_err = r_crc_err;
        n_fmt_err = r_fmt_err;
        n_ev      = EV_NONE;
        n_o_cmd   = r_cmd;
        n_o_seq   = r_seq;
        n_o_len   = r_len[6:0];
        w_clear   = 1'b0;

        unique case (r_phase)
            PH_SOF1: begin
                if (r_in_byte == SOF1_BYTE) begin
                    n_phase = PH_SOF2;
                end
            end
            PH_SOF2: begin
                if (r_in_byte == SOF2_BYTE) begin
                    n_crc   = CRC_INIT;
                    n_phase = PH_CMD;
                end else if (r_in_byte != SOF1_BYTE) begin
                    w_clear = 1'b1;
                end
            end
            PH_CMD: begin
                n_cmd   = r_in_byte;
                n_crc   = w_crc_b;
                n_phase = PH_SEQ;
            end
            PH_SEQ: begin
                n_seq   = r_in_byte;
                n_crc   = w_crc_b;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = LenW'(r_in_byte);
                n_crc   = w_crc_b;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_crc = w_crc_b;
                if (w_full_len > MaxLen) begin
                    n_ev      = EV_FORMAT;
                    n_o_len   = '0;
                    n_fmt_err = r_fmt_err + 32'd1;
                    w_clear   = 1'b1;
                end else begin
                    n_len   = LenW'(w_full_len);
                    n_seen  = '0;
                    n_phase = (w_full_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_seen = w_seen_inc;
                n_crc  = w_crc_b;
                if (LenW'(w_seen_inc) >= r_len) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = r_in_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                if ({r_in_byte, r_crc_lo} == r_crc) begin
                    n_ev   = EV_GOOD;
                    n_good = r_good + 32'd1;
                end else begin
                    n_ev      = EV_CRC;
                    n_crc_err = r_crc_err + 32'd1;
                end
                w_clear = 1'b1;
            end
            default: begin
                n_ev      = EV_FORMAT;
                n_o_len   = '0;
                n_fmt_err = r_fmt_err + 32'd1;
                w_clear   = 1'b1;
            end
        endcase

        if (w_clear) begin
            n_phase  = PH_SOF1;
            n_cmd    = '0;
            n_seq    = '0;
            n_len    = '0;
            n_seen   = '0;
            n_crc_lo = '0;
            n_crc    = CRC_INIT;
        end

        // with no event, report the registers as they stand after this byte
        if (n_ev == EV_NONE) begin
            n_o_cmd = n_cmd;
            n_o_seq = n_seq;
            n_o_len = n_len[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SOF1;
            r_cmd     <= '0;
            r_seq     <= '0;
            r_len     <= '0;
            r_seen    <= '0;
            r_crc_lo  <= '0;
            r_crc     <= CRC_INIT;
            r_good    <= '0;
            r_crc_err <= '0;
            r_fmt_err <= '0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_seq     <= n_seq;
            r_len     <= n_len;
            r_seen    <= n_seen;
            r_crc_lo  <= n_crc_lo;
            r_crc     <= n_crc;
            r_good    <= n_good;
            r_crc_err <= n_crc_err;
            r_fmt_err <= n_fmt_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ev    <= n_ev;
            r_o_cmd <= n_o_cmd;
            r_o_seq <= n_o_seq;
            r_o_len <= n_o_len;
        end
    end

    // counters change only when a result word is loaded, so they match it
    assign o_valid         = r_out_valid;
    assign o_event_res     = r_ev;
    assign o_frame_cmd     = r_o_cmd;
    assign o_frame_seq     = r_o_seq;
    assign o_frame_length  = r_o_len;
    assign o_good_frames   = r_good;
    assign o_crc_errors    = r_crc_err;
    assign o_format_errors = r_fmt_err;

endmodule
